// File: design/swm_pkg.sv
// ============================================================================
// swm_pkg
// Shared constants and types of the sliding window median unit.
// ============================================================================
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH        = 7;

    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

    typedef struct packed {
        logic clear;
        logic drop;
        logic insert;
    } swm_ctrl_t;

endpackage

// File: design/swm_cell.sv
// ============================================================================
// swm_cell
// One entry of the sorted window. Holds a sample, its age and a valid bit,
// and trades entries with its neighbors when the oldest sample is removed or
// a new sample is inserted in order.
// ============================================================================
module swm_cell #(
    parameter int KEY_W = 32,
    parameter int AGE_W = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  swm_pkg::swm_ctrl_t  ctrl,
    input  logic [KEY_W-1:0]    new_key,
    input  logic [AGE_W-1:0]    oldest_age,
    input  logic [KEY_W-1:0]    left_key,
    input  logic [AGE_W-1:0]    left_age,
    input  logic                left_valid,
    input  logic                left_cmp,
    input  logic                left_found,
    input  logic [KEY_W-1:0]    right_key,
    input  logic [AGE_W-1:0]    right_age,
    input  logic                right_valid,
    output logic [KEY_W-1:0]    key,
    output logic [AGE_W-1:0]    age,
    output logic                valid,
    output logic                cmp,
    output logic                found
);
    import swm_pkg::*;

    logic [KEY_W-1:0] key_reg, key_next;
    logic [AGE_W-1:0] age_reg, age_next;
    logic             valid_reg, valid_next;

    assign key   = key_reg;
    assign age   = age_reg;
    assign valid = valid_reg;
    assign cmp   = !valid_reg || ($signed(new_key) < $signed(key_reg));
    assign found = left_found || (valid_reg && (age_reg == oldest_age));

    always_comb begin
        key_next   = key_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.drop) begin
            if (found) begin
                key_next   = right_key;
                age_next   = right_age;
                valid_next = right_valid;
            end
        end else if (ctrl.insert) begin
            if (cmp) begin
                valid_next = left_valid;
                if (left_cmp) begin
                    key_next = left_key;
                    age_next = left_age + 1'b1;
                end else begin
                    key_next = new_key;
                    age_next = '0;
                end
            end else begin
                age_next = age_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
        age_reg <= age_next;
    end

endmodule

// File: design/sliding_window_median_unit.sv
// ============================================================================
// sliding_window_median_unit
// Running lower median over the last window_size signed samples.
// ============================================================================
// The window is kept in sorted order in a row of cells, one per entry, each
// tagged with its age. An item passes through accept, insert and result,
// with one removal before the insert for every old sample that must leave
// first, which is one in steady operation and more only after window_size
// has been lowered; the removal and the ordered insert each take one pass
// through the cell row. A new item is accepted while the previous result
// still waits at the output. A result appears once the window holds
// window_size samples; start_of_sequence empties the window before its
// sample enters.
module sliding_window_median_unit #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [swm_pkg::CFG_WIDTH-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_sample,
    input  logic                              s_start_of_sequence,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    m_median
);
    import swm_pkg::*;

    localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int SZ_W   = (FILL_W > CFG_WIDTH) ? FILL_W : CFG_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DROP,
        ST_CHECK
    } state_t;

    state_t                   state_reg;
    logic [CFG_WIDTH-1:0]     window_size_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic [SAMPLE_WIDTH-1:0]  sample_reg;
    logic                     m_valid_reg;
    logic [SAMPLE_WIDTH-1:0]  m_median_reg;

    logic [SZ_W-1:0]          size_ext;
    logic [FILL_W-1:0]        eff_size;
    logic [FILL_W-1:0]        mid;
    logic                     accept;
    logic                     do_drop;
    logic                     out_free;
    logic                     load_result;
    swm_ctrl_t                ctrl;
    logic [AGE_W-1:0]         oldest_age;
    logic [SAMPLE_WIDTH-1:0]  median_sel;

    logic [SAMPLE_WIDTH-1:0]  cell_key   [WINDOW_MAX];
    logic [AGE_W-1:0]         cell_age   [WINDOW_MAX];
    logic                     cell_valid [WINDOW_MAX];
    logic                     cell_cmp   [WINDOW_MAX];
    logic                     cell_found [WINDOW_MAX];

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_median = m_median_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        size_ext = SZ_W'(window_size_reg);
        if (size_ext == '0) begin
            size_ext = SZ_W'(1);
        end else if (size_ext > SZ_W'(WINDOW_MAX)) begin
            size_ext = SZ_W'(WINDOW_MAX);
        end
        eff_size = size_ext[FILL_W-1:0];
    end

    assign mid         = (eff_size - 1'b1) >> 1;
    assign oldest_age  = AGE_W'(fill_reg - 1'b1);
    assign do_drop     = (fill_reg >= eff_size) && (fill_reg != '0);
    assign load_result = (state_reg == ST_CHECK) && (fill_reg == eff_size) && out_free;

    always_comb begin
        ctrl        = '0;
        ctrl.clear  = (state_reg == ST_IDLE) && accept && s_start_of_sequence;
        ctrl.drop   = (state_reg == ST_DROP) && do_drop;
        ctrl.insert = (state_reg == ST_DROP) && !do_drop;
    end

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic [SAMPLE_WIDTH-1:0] l_key, r_key;
        logic [AGE_W-1:0]        l_age, r_age;
        logic                    l_valid, l_cmp, l_found, r_valid;

        if (i == 0) begin : g_first
            assign l_key   = '0;
            assign l_age   = '0;
            assign l_valid = 1'b1;
            assign l_cmp   = 1'b0;
            assign l_found = 1'b0;
        end else begin : g_inner
            assign l_key   = cell_key[i-1];
            assign l_age   = cell_age[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_cmp   = cell_cmp[i-1];
            assign l_found = cell_found[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_last
            assign r_key   = '0;
            assign r_age   = '0;
            assign r_valid = 1'b0;
        end else begin : g_body
            assign r_key   = cell_key[i+1];
            assign r_age   = cell_age[i+1];
            assign r_valid = cell_valid[i+1];
        end

        swm_cell #(
            .KEY_W (SAMPLE_WIDTH),
            .AGE_W (AGE_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_key     (sample_reg),
            .oldest_age  (oldest_age),
            .left_key    (l_key),
            .left_age    (l_age),
            .left_valid  (l_valid),
            .left_cmp    (l_cmp),
            .left_found  (l_found),
            .right_key   (r_key),
            .right_age   (r_age),
            .right_valid (r_valid),
            .key         (cell_key[i]),
            .age         (cell_age[i]),
            .valid       (cell_valid[i]),
            .cmp         (cell_cmp[i]),
            .found       (cell_found[i])
        );
    end

    always_comb begin
        median_sel = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (mid == FILL_W'(i)) begin
                median_sel = median_sel | cell_key[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WINDOW_SIZE_RESET;
            fill_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                window_size_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready && !load_result) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        sample_reg <= s_sample;
                        if (s_start_of_sequence) begin
                            fill_reg <= '0;
                        end
                        state_reg <= ST_DROP;
                    end
                end
                ST_DROP: begin
                    if (do_drop) begin
                        fill_reg <= fill_reg - 1'b1;
                    end else begin
                        fill_reg  <= fill_reg + 1'b1;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (fill_reg != eff_size) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        m_median_reg <= median_sel;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
